[hw/rtl/line_follower_steering_fsm_macros.svh]
// Assertion macros for the steering block checkers.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef LINE_FOLLOWER_STEERING_FSM_MACROS_SVH
`define LINE_FOLLOWER_STEERING_FSM_MACROS_SVH

// same-cycle implication, disabled in reset
`define LFS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define LFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/lfs_pkg.sv]
package lfs_pkg;

	// arming patterns for the right-angle turn mode
	localparam logic [7:0] PAT_ARM_WIDE   = 8'h81;
	localparam logic [7:0] PAT_ARM_NARROW = 8'hC3;
	// all sensors on the line
	localparam logic [7:0] PAT_ALL_ON     = 8'hFF;
	// corner patterns
	localparam logic [7:0] PAT_CORNER_L0  = 8'hF1;
	localparam logic [7:0] PAT_CORNER_L1  = 8'hE1;
	localparam logic [7:0] PAT_CORNER_L2  = 8'hC1;
	localparam logic [7:0] PAT_CORNER_R0  = 8'h8F;
	localparam logic [7:0] PAT_CORNER_R1  = 8'h87;
	localparam logic [7:0] PAT_CORNER_R2  = 8'h83;

	localparam logic [7:0] DUTY_PIVOT   = 8'd220;
	localparam logic [7:0] DUTY_DEFAULT = 8'd180;
	localparam logic [7:0] DUTY_STOP    = 8'd0;

	typedef struct packed {
		logic       left_forward;
		logic [7:0] left_duty;
		logic       right_forward;
		logic [7:0] right_duty;
	} cmd_t;

	typedef struct packed {
		logic turn_mode;
		logic pivot_left;
		logic pivot_right;
	} turn_state_t;

	// black-line table: both motors forward, duty pair by pattern
	function automatic cmd_t table_drive(logic [7:0] pattern);
		cmd_t c;
		c.left_forward  = 1'b1;
		c.right_forward = 1'b1;
		c.left_duty     = DUTY_DEFAULT;
		c.right_duty    = DUTY_DEFAULT;
		case (pattern)
			8'hCF, 8'hC7, 8'hDF: begin
				c.left_duty  = 8'd165;
				c.right_duty = 8'd200;
			end
			8'h9F, 8'h8F: begin
				c.left_duty  = 8'd145;
				c.right_duty = 8'd220;
			end
			8'hBF: begin
				c.left_duty  = 8'd90;
				c.right_duty = 8'd240;
			end
			8'hF3, 8'hE3, 8'hFB: begin
				c.left_duty  = 8'd200;
				c.right_duty = 8'd165;
			end
			8'hF9, 8'hF1: begin
				c.left_duty  = 8'd220;
				c.right_duty = 8'd145;
			end
			8'hFD: begin
				c.left_duty  = 8'd245;
				c.right_duty = 8'd90;
			end
			default: begin
				c.left_duty  = DUTY_DEFAULT;
				c.right_duty = DUTY_DEFAULT;
			end
		endcase
		return c;
	endfunction

	// left motor stopped, right pivoting forward
	function automatic cmd_t pivot_left_cmd();
		cmd_t c;
		c.left_forward  = 1'b0;
		c.left_duty     = DUTY_STOP;
		c.right_forward = 1'b1;
		c.right_duty    = DUTY_PIVOT;
		return c;
	endfunction

	// right motor stopped, left pivoting forward
	function automatic cmd_t pivot_right_cmd();
		cmd_t c;
		c.left_forward  = 1'b1;
		c.left_duty     = DUTY_PIVOT;
		c.right_forward = 1'b0;
		c.right_duty    = DUTY_STOP;
		return c;
	endfunction

endpackage

[hw/rtl/lfs_sample_if.sv]
// sensor sample channel
interface lfs_sample_if;
	logic       valid;
	logic       ready;
	logic [7:0] sensor_pattern;

	modport source (output valid, output sensor_pattern, input ready);
	modport sink (input valid, input sensor_pattern, output ready);
endinterface

[hw/rtl/lfs_cmd_if.sv]
// motor command channel
interface lfs_cmd_if;
	logic       valid;
	logic       ready;
	logic       left_forward;
	logic [7:0] left_duty;
	logic       right_forward;
	logic [7:0] right_duty;

	modport source (output valid, output left_forward, output left_duty,
		output right_forward, output right_duty, input ready);
	modport sink (input valid, input left_forward, input left_duty,
		input right_forward, input right_duty, output ready);
endinterface

[hw/rtl/line_follower_steering_fsm.sv]
// channel | dir | word
// sample  | in  | sensor_pattern[7:0]
// cmd     | out | left_forward, left_duty[7:0], right_forward, right_duty[7:0]
//
// One sample word per clock while cmd does not stall; an accepted word passes the input register,
// the steering logic and the output register before it shows on cmd.
// Reset clears both valid flags and the turn-mode flags; no clearing pass.
// A stall on cmd backs up into the input register, then drops sample.ready.
module line_follower_steering_fsm (
	input  logic        clk,
	input  logic        arst_n,
	lfs_sample_if.sink  sample,
	lfs_cmd_if.source   cmd
);

	logic          valid_s1;
	logic [7:0]    pattern_s1;
	logic          load_ok;
	logic          fire;
	lfs_pkg::cmd_t cmd_d;
	lfs_pkg::cmd_t cmd_q;

	assign fire = valid_s1 && load_ok;

	lfs_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (sample.valid),
		.in_pattern (sample.sensor_pattern),
		.in_ready   (sample.ready),
		.advance    (load_ok),
		.valid_s1   (valid_s1),
		.pattern_s1 (pattern_s1)
	);

	lfs_steer u_steer (
		.clk     (clk),
		.arst_n  (arst_n),
		.pattern (pattern_s1),
		.fire    (fire),
		.cmd     (cmd_d)
	);

	lfs_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (valid_s1),
		.cmd_d     (cmd_d),
		.load_ok   (load_ok),
		.out_ready (cmd.ready),
		.valid_q   (cmd.valid),
		.cmd_q     (cmd_q)
	);

	assign cmd.left_forward  = cmd_q.left_forward;
	assign cmd.left_duty     = cmd_q.left_duty;
	assign cmd.right_forward = cmd_q.right_forward;
	assign cmd.right_duty    = cmd_q.right_duty;

endmodule

[hw/rtl/lfs_in_stage.sv]
// Input register: holds one sample word until the steering stage takes it.
module lfs_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [7:0] in_pattern,
	output logic       in_ready,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] pattern_s1
);

	// free slot, or the held word leaves this cycle
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pattern_s1 <= in_pattern;
		end
	end

endmodule

[hw/rtl/lfs_steer.sv]
// Steering decision and turn-mode flags.
module lfs_steer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        pattern,
	input  logic              fire,
	output lfs_pkg::cmd_t     cmd
);

	lfs_pkg::turn_state_t state_q;
	lfs_pkg::turn_state_t state_d;
	logic                 is_arm;
	logic                 is_corner_l;
	logic                 is_corner_r;
	logic                 is_all_on;

	always_comb begin
		is_arm      = pattern inside {lfs_pkg::PAT_ARM_WIDE, lfs_pkg::PAT_ARM_NARROW};
		is_corner_l = pattern inside {lfs_pkg::PAT_CORNER_L0, lfs_pkg::PAT_CORNER_L1,
			lfs_pkg::PAT_CORNER_L2};
		is_corner_r = pattern inside {lfs_pkg::PAT_CORNER_R0, lfs_pkg::PAT_CORNER_R1,
			lfs_pkg::PAT_CORNER_R2};
		is_all_on   = (pattern == lfs_pkg::PAT_ALL_ON);
	end

	// priority: arming, held pivots, corner latching, table
	always_comb begin
		state_d = state_q;
		cmd     = lfs_pkg::table_drive(pattern);
		if (is_arm) begin
			state_d.turn_mode   = 1'b1;
			state_d.pivot_left  = 1'b0;
			state_d.pivot_right = 1'b0;
		end else if (state_q.turn_mode) begin
			if (state_q.pivot_left && is_all_on) begin
				cmd = lfs_pkg::pivot_left_cmd();
			end else if (state_q.pivot_right && is_all_on) begin
				cmd = lfs_pkg::pivot_right_cmd();
			end else if (is_corner_l) begin
				cmd                = lfs_pkg::pivot_left_cmd();
				state_d.pivot_left = 1'b1;
			end else if (is_corner_r) begin
				cmd                 = lfs_pkg::pivot_right_cmd();
				state_d.pivot_right = 1'b1;
			end
		end
	end

	// flags move only when a word is handed to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (fire) begin
			state_q <= state_d;
		end
	end

endmodule

[hw/rtl/lfs_out_stage.sv]
// Output register with valid/ready towards the motor side.
module lfs_out_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  lfs_pkg::cmd_t cmd_d,
	output logic          load_ok,
	input  logic          out_ready,
	output logic          valid_q,
	output lfs_pkg::cmd_t cmd_q
);

	// empty, or the held word is taken this cycle
	assign load_ok = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load_ok) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && load_ok) begin
			cmd_q <= cmd_d;
		end
	end

endmodule

[hw/rtl/lfs_checker.sv]
`include "line_follower_steering_fsm_macros.svh"

// Port-level checks for the steering block.
module lfs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       left_forward,
	input logic [7:0] left_duty,
	input logic       right_forward,
	input logic [7:0] right_duty
);

	logic        in_fire;
	logic        out_stall;
	logic        pivot_ok;
	logic [17:0] out_word;

	assign in_fire   = in_valid && in_ready;
	assign out_stall = out_valid && !out_ready;
	assign pivot_ok  = (left_duty == lfs_pkg::DUTY_STOP) && right_forward
		&& (right_duty == lfs_pkg::DUTY_PIVOT);
	assign out_word  = {left_forward, left_duty, right_forward, right_duty};

	// input only backs up when the output is stalled
	`LFS_ASSERT_NOW(a_stall_source, !in_ready, out_stall, "input stalled without output stall")

	// accepted word appears once the output side has room
	`LFS_ASSERT_NEXT(a_word_arrives, in_fire ##1 out_ready, out_valid, "accepted word lost")

	// a stopped left motor means a left pivot, right motor forward at pivot duty
	`LFS_ASSERT_NOW(a_left_pivot, out_valid && !left_forward, pivot_ok, "bad left pivot word")

	// held word stays put while stalled
	`LFS_ASSERT_NEXT(a_hold, out_stall, out_valid && $stable(out_word), "held word changed")

endmodule

bind line_follower_steering_fsm lfs_checker u_lfs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (sample.valid),
	.in_ready      (sample.ready),
	.out_valid     (cmd.valid),
	.out_ready     (cmd.ready),
	.left_forward  (cmd.left_forward),
	.left_duty     (cmd.left_duty),
	.right_forward (cmd.right_forward),
	.right_duty    (cmd.right_duty)
);
